[rtl/urc_pkg.sv]
// Shared types, constants and helpers for the ultrasonic ranging controller.
// No dependencies; imported by urc_step and ultrasonic_ranging_controller.
`default_nettype none

package urc_pkg;

  // Trigger timing in microsecond ticks
  localparam logic [15:0] PRE_LOW_US      = 16'd2;
  localparam logic [15:0] TRIGGER_HIGH_US = 16'd10;

  // Register indexes on the configuration port
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_POLL_PERIOD    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WAIT_TIMEOUT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ECHO_TIMEOUT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NEAR_THRESHOLD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NEAR_HOLD      = 3'd4;
  localparam int unsigned CFG_DATA_W = 16;

  // Register reset values
  localparam logic [15:0] POLL_PERIOD_RST    = 16'd90;
  localparam logic [15:0] WAIT_TIMEOUT_RST   = 16'd2300;
  localparam logic [14:0] ECHO_TIMEOUT_RST   = 15'd900;
  localparam logic [14:0] NEAR_THRESHOLD_RST = 15'd580;
  localparam logic [15:0] NEAR_HOLD_RST      = 16'd700;

  // floor(w / 58) == (w * 36158) >> 21 for every 15-bit w
  localparam logic [15:0] DIV58_MUL   = 16'd36158;
  localparam int unsigned DIV58_SHIFT = 21;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_PRE   = 3'd1,
    PH_HIGH  = 3'd2,
    PH_WAIT  = 3'd3,
    PH_COUNT = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    OUT_MEASURED = 2'd0,
    OUT_NO_ECHO  = 2'd1,
    OUT_TOO_LONG = 2'd2
  } outcome_t;

  typedef struct packed {
    logic [15:0] poll_period_ms;
    logic [15:0] wait_start_timeout_us;
    logic [14:0] echo_timeout_us;
    logic [14:0] near_threshold_us;
    logic [15:0] near_hold_ms;
  } cfg_t;

  typedef struct packed {
    phase_t      phase;
    logic [15:0] timer_us;
    logic [15:0] poll_age_ms;
    logic [16:0] near_age_ms;
    logic [16:0] near_age_at_poll;
    logic        near_seen;
    logic        near;
    logic [9:0]  distance_cm;
    logic [14:0] width_us;
  } state_t;

  typedef struct packed {
    logic        trigger_level;
    logic        near_flag;
    logic [9:0]  distance_cm;
    logic [14:0] pulse_width_us;
    logic        measurement_done;
    outcome_t    outcome;
  } res_t;

  function automatic logic [9:0] div58(input logic [14:0] w);
    logic [30:0] prod;
    prod = {1'b0, w} * DIV58_MUL;
    return prod[DIV58_SHIFT +: 10];
  endfunction

endpackage

`default_nettype wire

[rtl/urc_step.sv]
// Next-state and result logic for one microsecond tick of the ranging controller.
// Depends on urc_pkg.
`default_nettype none

module urc_step
  import urc_pkg::*;
(
  input  var cfg_t   cfg,
  input  var state_t cur,
  input  wire        echo_level,
  input  wire        ms_tick,
  output state_t     nxt,
  output res_t       res
);

  state_t      s;
  logic        trig;
  logic        done;
  outcome_t    outcome;
  logic        finish_echo;
  logic        near_now;
  logic        width_upd;
  logic        hold_flag;

  always_comb begin
    s           = cur;
    trig        = 1'b0;
    done        = 1'b0;
    outcome     = OUT_MEASURED;
    finish_echo = 1'b0;
    near_now    = 1'b0;
    width_upd   = 1'b0;

    // saturating millisecond ages
    if (ms_tick) begin
      if (s.poll_age_ms != '1) s.poll_age_ms = s.poll_age_ms + 16'd1;
      if (s.near_age_ms != '1) s.near_age_ms = s.near_age_ms + 17'd1;
    end

    if (s.phase == PH_IDLE && s.poll_age_ms >= cfg.poll_period_ms) begin
      s.poll_age_ms      = '0;
      s.near_age_at_poll = s.near_age_ms;
      s.phase            = PH_PRE;
      s.timer_us         = '0;
    end

    hold_flag = s.near_seen && (s.near_age_at_poll <= {1'b0, cfg.near_hold_ms});

    unique case (s.phase)
      PH_IDLE: ;
      PH_PRE: begin
        if (s.timer_us + 16'd1 >= PRE_LOW_US) begin
          s.phase    = PH_HIGH;
          s.timer_us = '0;
        end else begin
          s.timer_us = s.timer_us + 16'd1;
        end
      end
      PH_HIGH: begin
        trig = 1'b1;
        if (s.timer_us + 16'd1 >= TRIGGER_HIGH_US) begin
          s.phase    = PH_WAIT;
          s.timer_us = '0;
        end else begin
          s.timer_us = s.timer_us + 16'd1;
        end
      end
      PH_WAIT: begin
        if (echo_level) begin
          s.phase     = PH_COUNT;
          s.timer_us  = 16'd1;
          finish_echo = 1'b1;
        end else if (s.timer_us >= cfg.wait_start_timeout_us) begin
          // count would pass the timeout on this tick
          done       = 1'b1;
          outcome    = OUT_NO_ECHO;
          s.near     = hold_flag;
          s.phase    = PH_IDLE;
          s.timer_us = '0;
        end else begin
          s.timer_us = s.timer_us + 16'd1;
        end
      end
      PH_COUNT: begin
        if (echo_level) begin
          s.timer_us  = s.timer_us + 16'd1;
          finish_echo = 1'b1;
        end else begin
          s.width_us = s.timer_us[14:0];
          width_upd  = 1'b1;
          near_now   = (s.timer_us[14:0] <= cfg.near_threshold_us);
          if (near_now) begin
            s.near_seen   = 1'b1;
            s.near_age_ms = {1'b0, s.poll_age_ms};
          end
          s.near     = near_now | hold_flag;
          done       = 1'b1;
          s.phase    = PH_IDLE;
          s.timer_us = '0;
        end
      end
      default: begin
        s.phase    = PH_IDLE;
        s.timer_us = '0;
      end
    endcase

    // echo held high past its timeout: clamp
    if (finish_echo && s.timer_us > {1'b0, cfg.echo_timeout_us}) begin
      s.width_us = cfg.echo_timeout_us;
      width_upd  = 1'b1;
      s.near     = hold_flag;
      done       = 1'b1;
      outcome    = OUT_TOO_LONG;
      s.phase    = PH_IDLE;
      s.timer_us = '0;
    end
  end

  always_comb begin
    nxt = s;
    if (width_upd) nxt.distance_cm = div58(s.width_us);
  end

  assign res.trigger_level    = trig;
  assign res.near_flag        = s.near;
  assign res.distance_cm      = nxt.distance_cm;
  assign res.pulse_width_us   = s.width_us;
  assign res.measurement_done = done;
  assign res.outcome          = outcome;

endmodule

`default_nettype wire

[rtl/ultrasonic_ranging_controller.sv]
// Ultrasonic ranging controller: top level with configuration registers,
// state register and output skid stage. Depends on urc_pkg and urc_step.
//
// One request is one microsecond tick (echo level, millisecond marker) and
// gives exactly one result: trigger level, near flag, last distance and width,
// and a done strobe with outcome on the tick a measurement ends. A request is
// taken every cycle while in_stall is low; its result is registered.
// The next state is ready at the same edge, so the tick-to-tick dependency
// closes through a single register and costs nothing in rate. Two result slots
// (output register plus skid) let a request be taken while a result waits;
// in_stall rises only when both are full. Distance uses a 15x16 reciprocal
// multiply by 1/58 in the same cycle.
`default_nettype none

module ultrasonic_ranging_controller
  import urc_pkg::*;
(
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  cfg_we,
  input  wire [CFG_IDX_W-1:0]  cfg_index,
  input  wire [CFG_DATA_W-1:0] cfg_wdata,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  wire                  in_echo_level,
  input  wire                  in_ms_tick,
  output logic                 out_valid,
  input  wire                  out_stall,
  output logic                 out_trigger_level,
  output logic                 out_near_flag,
  output logic [9:0]           out_distance_cm,
  output logic [14:0]          out_pulse_width_us,
  output logic                 out_measurement_done,
  output logic [1:0]           out_outcome
);

  cfg_t   cfg_r;
  state_t state_r, state_nxt;
  res_t   res_nxt;
  res_t   out_res_r, skid_res_r;
  logic   out_valid_r, skid_valid_r;
  logic   in_acc, out_acc;

  assign in_stall = skid_valid_r;
  assign in_acc   = in_valid && !skid_valid_r;
  assign out_acc  = out_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.poll_period_ms        <= POLL_PERIOD_RST;
      cfg_r.wait_start_timeout_us <= WAIT_TIMEOUT_RST;
      cfg_r.echo_timeout_us       <= ECHO_TIMEOUT_RST;
      cfg_r.near_threshold_us     <= NEAR_THRESHOLD_RST;
      cfg_r.near_hold_ms          <= NEAR_HOLD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_POLL_PERIOD:    cfg_r.poll_period_ms        <= cfg_wdata;
        REG_WAIT_TIMEOUT:   cfg_r.wait_start_timeout_us <= cfg_wdata;
        REG_ECHO_TIMEOUT:   cfg_r.echo_timeout_us       <= cfg_wdata[14:0];
        REG_NEAR_THRESHOLD: cfg_r.near_threshold_us     <= cfg_wdata[14:0];
        REG_NEAR_HOLD:      cfg_r.near_hold_ms          <= cfg_wdata;
        default: ;
      endcase
    end
  end

  urc_step u_step (
    .cfg        (cfg_r),
    .cur        (state_r),
    .echo_level (in_echo_level),
    .ms_tick    (in_ms_tick),
    .nxt        (state_nxt),
    .res        (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase            <= PH_IDLE;
      state_r.timer_us         <= '0;
      state_r.poll_age_ms      <= '0;
      state_r.near_age_ms      <= '0;
      state_r.near_age_at_poll <= '0;
      state_r.near_seen        <= 1'b0;
      state_r.near             <= 1'b0;
      state_r.distance_cm      <= '0;
      state_r.width_us         <= '0;
    end else if (in_acc) begin
      state_r <= state_nxt;
    end
  end

  // output register with one skid slot behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_acc) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= in_acc;
      end
    end else if (in_acc) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_acc) begin
      if (skid_valid_r) out_res_r <= skid_res_r;
      else if (in_acc)  out_res_r <= res_nxt;
    end else if (in_acc) begin
      skid_res_r <= res_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_trigger_level    = out_res_r.trigger_level;
  assign out_near_flag        = out_res_r.near_flag;
  assign out_distance_cm      = out_res_r.distance_cm;
  assign out_pulse_width_us   = out_res_r.pulse_width_us;
  assign out_measurement_done = out_res_r.measurement_done;
  assign out_outcome          = out_res_r.outcome;

  // skid slot only fills behind a held output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid slot full with output register empty");

  // outcome code carries meaning only on a done tick
  a_outcome_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_res_r.measurement_done) |-> (out_res_r.outcome == OUT_MEASURED))
    else $error("outcome set without measurement_done");

  // a finished measurement always returns to idle
  a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && res_nxt.measurement_done) |=> (state_r.phase == PH_IDLE))
    else $error("measurement finished but phase not idle");

endmodule

`default_nettype wire
